// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted key table
// Command and status codes, the cell operation code and the per-cell
// compare flags that travel from the cells to the controller.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Width of the position and range count result fields.
   localparam int POS_WIDTH    = 7;
   localparam int STATUS_WIDTH = 3;
   localparam int CMD_WIDTH    = 2;

   // Command codes of an input beat.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_FIND    = 2'd2,
      CMD_EXTRACT = 2'd3
   } cmd_type;

   // Status codes of a result beat.
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUP       = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_BAD_RANGE = 3'd4,
      STATUS_EMPTY     = 3'd5
   } status_type;

   // Operation that every cell applies to its key.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // Registered compare result of one cell against the probe key.
   typedef struct packed {
      logic lt;   // occupied and stored key below the probe
      logic eq;   // occupied and stored key equal to the probe
   } cell_flags_type;

endpackage

// File: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one key, compares it with the probe key and moves keys to and from
// its neighbors for insert, remove and rotation.
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                    clock,
   input  skt_pkg::cell_op_type    op,
   input  logic                    occupied,
   input  logic [KEY_WIDTH-1:0]    probe_key,
   input  logic [KEY_WIDTH-1:0]    insert_key,
   input  logic                    left_lt,
   input  logic [KEY_WIDTH-1:0]    left_key,
   input  logic [KEY_WIDTH-1:0]    right_key,
   output logic [KEY_WIDTH-1:0]    key,
   output skt_pkg::cell_flags_type flags
);

   logic [KEY_WIDTH-1:0]    key_ff;
   logic [KEY_WIDTH-1:0]    key_in;
   skt_pkg::cell_flags_type flags_ff;
   skt_pkg::cell_flags_type flags_in;

   // Compare the stored key with the probe; empty slots never match.
   always_comb begin
      flags_in.lt = occupied && (key_ff < probe_key);
      flags_in.eq = occupied && (key_ff == probe_key);
   end

   // Insert and remove keep the key of slots below the sorted position and shift the others; rotate shifts every slot.
   always_comb begin
      case (op)
         skt_pkg::CELL_INSERT: begin
            if (flags_ff.lt) begin
               key_in = key_ff;
            end else if (left_lt) begin
               key_in = insert_key;
            end else begin
               key_in = left_key;
            end
         end
         skt_pkg::CELL_REMOVE: key_in = flags_ff.lt ? key_ff : right_key;
         skt_pkg::CELL_ROTATE: key_in = right_key;
         default:              key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      flags_ff <= flags_in;
   end

   assign key   = key_ff;
   assign flags = flags_ff;

endmodule

// File: hdl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of distinct keys
// A row of TABLE_DEPTH cells keeps the keys in ascending order and supports
// insert, remove, find and range extract, one command at a time.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   request   start / busy     req_cmd, req_key, req_key_end
//   response  rsp_valid strobe rsp_status, rsp_position, rsp_key_out,
//                              rsp_range_count, rsp_last
//
// A command is taken when start is high and busy is low. Insert, remove and
// find compare in every cell, encode the position, then act.
// A range extract runs these steps twice for its two searches, then the row of
// cells rotates through all TABLE_DEPTH slots, one slot a cycle, and emits
// the keys of the range on the way; the rotation sets its length.
// Reset empties the table. Each result beat is on the ports
// for one cycle only, and the receiver cannot stall it.
//
module sorted_key_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [skt_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  logic [KEY_WIDTH-1:0]              req_key,
   input  logic [KEY_WIDTH-1:0]              req_key_end,
   output logic                              rsp_valid,
   output logic [skt_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic [skt_pkg::POS_WIDTH-1:0]     rsp_position,
   output logic [KEY_WIDTH-1:0]              rsp_key_out,
   output logic [skt_pkg::POS_WIDTH-1:0]     rsp_range_count,
   output logic                              rsp_last
);

   localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_WIDTH = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FIND,
      ST_EXEC,
      ST_SCAN
   } state_type;

   state_type                         state_ff;
   logic                              end_pass_ff;
   skt_pkg::cmd_type                  cmd_ff;
   logic [KEY_WIDTH-1:0]              key_ff;
   logic [KEY_WIDTH-1:0]              key_end_ff;
   logic [KEY_WIDTH-1:0]              probe_ff;
   logic [CNT_WIDTH-1:0]              count_ff;
   logic [CNT_WIDTH-1:0]              pos_ff;
   logic                              hit_ff;
   logic [CNT_WIDTH-1:0]              first_ff;
   logic [CNT_WIDTH-1:0]              final_ff;
   logic [IDX_WIDTH-1:0]              scan_ff;
   logic                              rsp_valid_ff;
   skt_pkg::status_type               rsp_status_ff;
   logic [CNT_WIDTH-1:0]              rsp_position_ff;
   logic [KEY_WIDTH-1:0]              rsp_key_out_ff;
   logic [CNT_WIDTH-1:0]              rsp_range_count_ff;
   logic                              rsp_last_ff;

   skt_pkg::cell_op_type              cell_op;
   skt_pkg::cell_flags_type           flags [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0]              cell_key [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]            occupied;
   logic [CNT_WIDTH-1:0]              pos_in;
   logic                              hit_in;
   logic                              accept;
   logic                              full;
   logic [CNT_WIDTH-1:0]              scan_pos;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign full     = (count_ff == CNT_WIDTH'(TABLE_DEPTH));
   assign scan_pos = CNT_WIDTH'(scan_ff);

   // Row of cells, each handing keys to its neighbors.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign occupied[i] = (CNT_WIDTH'(i) < count_ff);
      skt_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .occupied   (occupied[i]),
         .probe_key  (probe_ff),
         .insert_key (key_ff),
         .left_lt    ((i == 0) ? 1'b1 : flags[(i + TABLE_DEPTH - 1) % TABLE_DEPTH].lt),
         .left_key   (cell_key[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .right_key  (cell_key[(i + 1) % TABLE_DEPTH]),
         .key        (cell_key[i]),
         .flags      (flags[i])
      );
   end

   // Lower bound: the slot where the below-probe run of cells ends.
   always_comb begin
      pos_in = flags[TABLE_DEPTH-1].lt ? CNT_WIDTH'(TABLE_DEPTH) : '0;
      hit_in = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!flags[i].lt && (i == 0 || flags[(i + TABLE_DEPTH - 1) % TABLE_DEPTH].lt)) begin
            pos_in = pos_in | CNT_WIDTH'(i);
         end
         hit_in = hit_in | flags[i].eq;
      end
   end

   // Cell operation for this cycle.
   always_comb begin
      cell_op = skt_pkg::CELL_HOLD;
      if (state_ff == ST_EXEC) begin
         if (cmd_ff == skt_pkg::CMD_INSERT && !hit_ff && !full) begin
            cell_op = skt_pkg::CELL_INSERT;
         end else if (cmd_ff == skt_pkg::CMD_REMOVE && count_ff != '0 && hit_ff) begin
            cell_op = skt_pkg::CELL_REMOVE;
         end
      end else if (state_ff == ST_SCAN) begin
         cell_op = skt_pkg::CELL_ROTATE;
      end
   end

   // Command sequencer with the registered result beat.
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         end_pass_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff      <= skt_pkg::cmd_type'(req_cmd);
                  key_ff      <= req_key;
                  key_end_ff  <= req_key_end;
                  probe_ff    <= req_key;
                  end_pass_ff <= 1'b0;
                  state_ff    <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_FIND;
            end
            ST_FIND: begin
               pos_ff   <= pos_in;
               hit_ff   <= hit_in;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               rsp_position_ff    <= pos_ff;
               rsp_key_out_ff     <= key_ff;
               rsp_range_count_ff <= '0;
               rsp_last_ff        <= 1'b1;
               rsp_valid_ff       <= 1'b1;
               state_ff           <= ST_IDLE;
               unique case (cmd_ff) inside
                  skt_pkg::CMD_INSERT: begin
                     if (hit_ff) begin
                        rsp_status_ff <= skt_pkg::STATUS_DUP;
                     end else if (full) begin
                        rsp_status_ff <= skt_pkg::STATUS_FULL;
                     end else begin
                        rsp_status_ff <= skt_pkg::STATUS_OK;
                        count_ff      <= count_ff + 1'b1;
                     end
                  end
                  skt_pkg::CMD_REMOVE, skt_pkg::CMD_FIND: begin
                     if (count_ff == '0) begin
                        rsp_status_ff   <= skt_pkg::STATUS_EMPTY;
                        rsp_position_ff <= '0;
                     end else if (!hit_ff) begin
                        rsp_status_ff <= skt_pkg::STATUS_NOT_FOUND;
                     end else begin
                        rsp_status_ff <= skt_pkg::STATUS_OK;
                        if (cmd_ff == skt_pkg::CMD_REMOVE) begin
                           count_ff <= count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     // Range extract: start key pass, then end key pass.
                     if (key_ff > key_end_ff) begin
                        rsp_status_ff   <= skt_pkg::STATUS_BAD_RANGE;
                        rsp_position_ff <= '0;
                     end else if (count_ff == '0) begin
                        rsp_status_ff   <= skt_pkg::STATUS_EMPTY;
                        rsp_position_ff <= '0;
                     end else if (!hit_ff) begin
                        rsp_status_ff <= skt_pkg::STATUS_NOT_FOUND;
                        if (end_pass_ff) begin
                           rsp_key_out_ff <= key_end_ff;
                        end
                     end else if (!end_pass_ff) begin
                        rsp_valid_ff <= 1'b0;
                        first_ff     <= pos_ff;
                        probe_ff     <= key_end_ff;
                        end_pass_ff  <= 1'b1;
                        state_ff     <= ST_LOAD;
                     end else begin
                        rsp_valid_ff <= 1'b0;
                        final_ff     <= pos_ff;
                        scan_ff      <= '0;
                        state_ff     <= ST_SCAN;
                     end
                  end
               endcase
            end
            ST_SCAN: begin
               // Slot zero shows the key of index scan_ff on this cycle.
               if (scan_pos >= first_ff && scan_pos <= final_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_status_ff      <= skt_pkg::STATUS_OK;
                  rsp_position_ff    <= scan_pos;
                  rsp_key_out_ff     <= cell_key[0];
                  rsp_range_count_ff <= final_ff - first_ff + 1'b1;
                  rsp_last_ff        <= (scan_pos == final_ff);
               end
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == IDX_WIDTH'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = skt_pkg::POS_WIDTH'(rsp_position_ff);
   assign rsp_key_out     = rsp_key_out_ff;
   assign rsp_range_count = skt_pkg::POS_WIDTH'(rsp_range_count_ff);
   assign rsp_last        = rsp_last_ff;

endmodule

// File: tb/sorted_key_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb: self-checking testbench of the sorted key table
// A queue of commands feeds a clocked driver on the start / busy handshake.
// A clocked monitor keeps its own copy of the ordered table, works out the
// result beats of every accepted command and checks each strobed result beat
// field by field against the oldest one outstanding. Directed commands cover
// the empty table, duplicates, misses and bad ranges. A full-table phase and
// a long random mix over a small key pool follow.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int FILL_COUNT  = 66;
   localparam int REMOVE_COUNT = 48;
   localparam int RANDOM_COUNT = 54;
   localparam int TAIL_CYCLES  = 120;
   localparam int CYCLE_LIMIT  = 300000;

   // One command beat waiting to be driven.
   typedef struct {
      skt_pkg::cmd_type     cmd;
      logic [KEY_WIDTH-1:0] key;
      logic [KEY_WIDTH-1:0] key_end;
      int unsigned          gap;
      bit                   drain;
   } table_cmd_type;

   // One result beat the table is expected to produce.
   typedef struct {
      skt_pkg::status_type                status;
      logic [skt_pkg::POS_WIDTH-1:0]      position;
      logic [KEY_WIDTH-1:0]               key_out;
      logic [skt_pkg::POS_WIDTH-1:0]      range_count;
      logic                               last;
   } rsp_beat_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [skt_pkg::CMD_WIDTH-1:0]     req_cmd = '0;
   logic [KEY_WIDTH-1:0]              req_key = '0;
   logic [KEY_WIDTH-1:0]              req_key_end = '0;
   logic                              rsp_valid;
   logic [skt_pkg::STATUS_WIDTH-1:0]  rsp_status;
   logic [skt_pkg::POS_WIDTH-1:0]     rsp_position;
   logic [KEY_WIDTH-1:0]              rsp_key_out;
   logic [skt_pkg::POS_WIDTH-1:0]     rsp_range_count;
   logic                              rsp_last;

   table_cmd_type     command_queue[$];
   rsp_beat_type      expected_rsp_beats[$];
   logic              drained = 1'b1;
   int unsigned       idle_count = 0;
   int unsigned       cmd_index = 0;
   bit                drain_next = 1'b0;
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   logic [KEY_WIDTH-1:0] fill_keys[FILL_COUNT];

   // Shadow of the ordered table.
   logic [KEY_WIDTH-1:0] shadow_keys[TABLE_DEPTH];
   int unsigned          shadow_count = 0;

   sorted_key_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_key_end    (req_key_end),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_key_out    (rsp_key_out),
      .rsp_range_count(rsp_range_count),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // First slot whose stored key is not below k.
   function automatic int unsigned lower_bound(logic [KEY_WIDTH-1:0] k);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic bit key_at(int unsigned p, logic [KEY_WIDTH-1:0] k);
      return (p < shadow_count) && (shadow_keys[p] == k);
   endfunction

   task automatic push_beat(input skt_pkg::status_type st, input int unsigned pos,
                            input logic [KEY_WIDTH-1:0] k, input int unsigned cnt,
                            input logic last);
      rsp_beat_type b;
      b.status      = st;
      b.position    = pos[skt_pkg::POS_WIDTH-1:0];
      b.key_out     = k;
      b.range_count = cnt[skt_pkg::POS_WIDTH-1:0];
      b.last        = last;
      expected_rsp_beats.push_back(b);
   endtask

   // Apply one command to the shadow table and queue its result beats.
   task automatic apply_table_command(input skt_pkg::cmd_type cmd,
                                      input logic [KEY_WIDTH-1:0] k,
                                      input logic [KEY_WIDTH-1:0] ke);
      int unsigned p;
      int unsigned q;
      int unsigned n;
      p = lower_bound(k);
      case (cmd) inside
         skt_pkg::CMD_INSERT: begin
            if (key_at(p, k)) begin
               push_beat(skt_pkg::STATUS_DUP, p, k, 0, 1'b1);
            end else if (shadow_count >= TABLE_DEPTH) begin
               push_beat(skt_pkg::STATUS_FULL, p, k, 0, 1'b1);
            end else begin
               for (int i = shadow_count; i > p; i--) shadow_keys[i] = shadow_keys[i-1];
               shadow_keys[p] = k;
               shadow_count++;
               push_beat(skt_pkg::STATUS_OK, p, k, 0, 1'b1);
            end
         end
         skt_pkg::CMD_REMOVE, skt_pkg::CMD_FIND: begin
            if (shadow_count == 0) begin
               push_beat(skt_pkg::STATUS_EMPTY, 0, k, 0, 1'b1);
            end else if (!key_at(p, k)) begin
               push_beat(skt_pkg::STATUS_NOT_FOUND, p, k, 0, 1'b1);
            end else begin
               if (cmd == skt_pkg::CMD_REMOVE) begin
                  for (int i = p; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
                  shadow_count--;
               end
               push_beat(skt_pkg::STATUS_OK, p, k, 0, 1'b1);
            end
         end
         default: begin
            // Range extract: bad order is checked before the empty table.
            q = lower_bound(ke);
            if (k > ke) begin
               push_beat(skt_pkg::STATUS_BAD_RANGE, 0, k, 0, 1'b1);
            end else if (shadow_count == 0) begin
               push_beat(skt_pkg::STATUS_EMPTY, 0, k, 0, 1'b1);
            end else if (!key_at(p, k)) begin
               push_beat(skt_pkg::STATUS_NOT_FOUND, p, k, 0, 1'b1);
            end else if (!key_at(q, ke)) begin
               push_beat(skt_pkg::STATUS_NOT_FOUND, q, ke, 0, 1'b1);
            end else begin
               n = q - p + 1;
               for (int i = 0; i < n; i++)
                  push_beat(skt_pkg::STATUS_OK, p + i, shadow_keys[p + i], n, (i + 1 == n));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
   endtask

   // Queue one command with its idle gap; some stretches run with no gap.
   task automatic add_command(input skt_pkg::cmd_type c, input logic [KEY_WIDTH-1:0] k,
                              input logic [KEY_WIDTH-1:0] ke);
      table_cmd_type t;
      t.cmd     = c;
      t.key     = k;
      t.key_end = ke;
      if ((cmd_index / 16) % 3 == 0) t.gap = 0;
      else t.gap = $urandom_range(0, 17);
      t.drain   = drain_next || ($urandom_range(0, 39) == 0);
      drain_next = 1'b0;
      cmd_index++;
      command_queue.push_back(t);
   endtask

   function automatic logic [KEY_WIDTH-1:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return fill_keys[$urandom_range(0, FILL_COUNT-1)];
      else if (r < 85) return $urandom;
      else if (r < 92) return '0;
      else return '1;
   endfunction

   // Driver: holds a beat while busy, then idles for the next beat's gap.
   always @(posedge clock) begin
      if (reset) begin
         start       <= 1'b0;
         req_cmd     <= '0;
         req_key     <= '0;
         req_key_end <= '0;
         idle_count  <= 0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (command_queue.size() == 0) begin
         start <= 1'b0;
      end else if (idle_count < command_queue[0].gap) begin
         start      <= 1'b0;
         idle_count <= idle_count + 1;
      end else if (command_queue[0].drain && (start || !drained)) begin
         // Hold off until every outstanding result beat has arrived.
         start <= 1'b0;
      end else begin
         start       <= 1'b1;
         req_cmd     <= command_queue[0].cmd;
         req_key     <= command_queue[0].key;
         req_key_end <= command_queue[0].key_end;
         idle_count  <= 0;
         void'(command_queue.pop_front());
      end
   end

   // Monitor: check the strobed beat, then predict for a beat accepted now.
   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type want;
      if (reset) begin
         shadow_count = 0;
         drained <= 1'b1;
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_beats.size() == 0) begin
               report_mismatch("unexpected result beat, key_out", rsp_key_out, 0);
            end else begin
               want = expected_rsp_beats.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_position !== want.position)
                  report_mismatch("position", rsp_position, want.position);
               if (rsp_key_out !== want.key_out)
                  report_mismatch("key_out", rsp_key_out, want.key_out);
               if (rsp_range_count !== want.range_count)
                  report_mismatch("range_count", rsp_range_count, want.range_count);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (start && !busy)
            apply_table_command(skt_pkg::cmd_type'(req_cmd), req_key, req_key_end);
         drained <= (expected_rsp_beats.size() == 0);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [KEY_WIDTH-1:0] lo_key;
      logic [KEY_WIDTH-1:0] hi_key;
      logic [KEY_WIDTH-1:0] a;
      logic [KEY_WIDTH-1:0] b;
      int unsigned r;

      // Directed: empty table, ordering edges, duplicates, misses, ranges.
      add_command(skt_pkg::CMD_FIND,    32'd5, $urandom);
      add_command(skt_pkg::CMD_REMOVE,  32'd5, $urandom);
      add_command(skt_pkg::CMD_EXTRACT, 32'd1, 32'd2);
      add_command(skt_pkg::CMD_EXTRACT, 32'd9, 32'd3);
      add_command(skt_pkg::CMD_INSERT,  32'd100, $urandom);
      add_command(skt_pkg::CMD_INSERT,  32'd0, $urandom);
      add_command(skt_pkg::CMD_INSERT,  32'hFFFF_FFFF, $urandom);
      add_command(skt_pkg::CMD_INSERT,  32'd100, $urandom);
      add_command(skt_pkg::CMD_INSERT,  32'd50, $urandom);
      add_command(skt_pkg::CMD_FIND,    32'd100, $urandom);
      add_command(skt_pkg::CMD_FIND,    32'd75, $urandom);
      add_command(skt_pkg::CMD_FIND,    32'hFFFF_FFFE, $urandom);
      add_command(skt_pkg::CMD_EXTRACT, 32'd0, 32'hFFFF_FFFF);
      add_command(skt_pkg::CMD_EXTRACT, 32'd100, 32'd100);
      add_command(skt_pkg::CMD_EXTRACT, 32'd1, 32'd100);
      add_command(skt_pkg::CMD_EXTRACT, 32'd0, 32'd99);
      add_command(skt_pkg::CMD_EXTRACT, 32'd100, 32'd50);
      add_command(skt_pkg::CMD_REMOVE,  32'd50, $urandom);
      add_command(skt_pkg::CMD_REMOVE,  32'd51, $urandom);
      add_command(skt_pkg::CMD_REMOVE,  32'hFFFF_FFFF, $urandom);
      add_command(skt_pkg::CMD_REMOVE,  32'd0, $urandom);
      add_command(skt_pkg::CMD_REMOVE,  32'd100, $urandom);
      add_command(skt_pkg::CMD_FIND,    32'd0, $urandom);

      // Fill the empty table past its depth, then extract the whole of it.
      for (int i = 0; i < FILL_COUNT; i++) fill_keys[i] = $urandom;
      lo_key = fill_keys[0];
      hi_key = fill_keys[0];
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         if (fill_keys[i] < lo_key) lo_key = fill_keys[i];
         if (fill_keys[i] > hi_key) hi_key = fill_keys[i];
      end
      drain_next = 1'b1;
      for (int i = 0; i < FILL_COUNT; i++)
         add_command(skt_pkg::CMD_INSERT, fill_keys[i], $urandom);
      add_command(skt_pkg::CMD_INSERT, fill_keys[3], $urandom);
      add_command(skt_pkg::CMD_EXTRACT, lo_key, hi_key);
      for (int i = 0; i < 4; i++) begin
         a = fill_keys[$urandom_range(0, TABLE_DEPTH-1)];
         b = fill_keys[$urandom_range(0, TABLE_DEPTH-1)];
         if (a > b) add_command(skt_pkg::CMD_EXTRACT, b, a);
         else add_command(skt_pkg::CMD_EXTRACT, a, b);
      end
      for (int i = 0; i < 4; i++)
         add_command(skt_pkg::CMD_FIND, fill_keys[$urandom_range(0, TABLE_DEPTH-1)],
                     $urandom);

      // Thin the table out so the random mix sees hits and misses.
      drain_next = 1'b1;
      for (int i = 0; i < REMOVE_COUNT; i++)
         add_command(skt_pkg::CMD_REMOVE, fill_keys[i], $urandom);

      // Random mix over a small key pool, with some fully random noise.
      drain_next = 1'b1;
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            add_command(skt_pkg::cmd_type'($urandom_range(0, 3)), $urandom, $urandom);
         end else if (r < 45) begin
            add_command(skt_pkg::CMD_INSERT, pick_key(), $urandom);
         end else if (r < 60) begin
            add_command(skt_pkg::CMD_REMOVE, pick_key(), $urandom);
         end else if (r < 75) begin
            add_command(skt_pkg::CMD_FIND, pick_key(), $urandom);
         end else begin
            a = pick_key();
            b = pick_key();
            if (a > b) begin
               lo_key = b;
               hi_key = a;
            end else begin
               lo_key = a;
               hi_key = b;
            end
            if ($urandom_range(0, 9) == 0) add_command(skt_pkg::CMD_EXTRACT, hi_key, lo_key);
            else add_command(skt_pkg::CMD_EXTRACT, lo_key, hi_key);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait until every beat is taken and every result beat has come.
      @(negedge clock);
      while (command_queue.size() != 0 || start || expected_rsp_beats.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
